// ===== src/palette_nearest_color_match_defines.svh =====
// Assertion macros shared by the palette colour match RTL.
`ifndef PALETTE_NEAREST_COLOR_MATCH_DEFINES_SVH
`define PALETTE_NEAREST_COLOR_MATCH_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define PNC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet during reset.
`define PNC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/pnc_pkg.sv =====
// Shared types, constants and helpers for the palette colour match block.
package pnc_pkg;

   localparam int PNC_ENTRIES_DEFAULT = 256;
   localparam int ENTRY_W             = 24;
   localparam int CHAN_W              = 8;
   localparam int SQ_W                = 16;
   localparam int DIST_W              = 18;
   localparam int WORD_W              = 32;
   localparam int INDEX_W             = 8;
   localparam int CODE_W              = 15;

   localparam logic [0:0] OP_LOAD    = 1'b0;
   localparam logic [0:0] OP_QUERY   = 1'b1;
   localparam logic [0:0] KIND_ACK   = 1'b0;
   localparam logic [0:0] KIND_MATCH = 1'b1;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

   // Control that travels with each palette entry into the distance unit.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } scan_ctl_type;

   // Widen a 5-bit component to 8 bits: (c << 3) + 4.
   function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] c5);
      return {c5, 3'b100};
   endfunction

endpackage

// ===== src/pnc_cell.sv =====
// One palette entry of the rotating palette ring.
module pnc_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load_en,
   input  logic [pnc_pkg::ENTRY_W-1:0] load_data,
   input  logic                      shift_en,
   input  logic [pnc_pkg::ENTRY_W-1:0] shift_data,
   output logic [pnc_pkg::ENTRY_W-1:0] entry_q
);
   import pnc_pkg::*;

   logic [ENTRY_W-1:0] entry_ff;
   logic [ENTRY_W-1:0] entry_in;

   always_comb begin
      priority if (load_en) begin
         entry_in = load_data;
      end else if (shift_en) begin
         entry_in = shift_data;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry_q = entry_ff;

endmodule

// ===== src/pnc_dist.sv =====
// Squared RGB distance and running minimum over the entries leaving the ring.
module pnc_dist #(
   parameter int IDX_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pnc_pkg::scan_ctl_type       ctl_in,
   input  logic [IDX_W-1:0]            idx_in,
   input  logic [pnc_pkg::ENTRY_W-1:0] entry_in,
   input  logic [pnc_pkg::CHAN_W-1:0]  query_red,
   input  logic [pnc_pkg::CHAN_W-1:0]  query_green,
   input  logic [pnc_pkg::CHAN_W-1:0]  query_blue,
   output logic [IDX_W-1:0]            best_index,
   output logic [pnc_pkg::DIST_W-1:0]  best_distance,
   output logic                        done
);
   import pnc_pkg::*;

   // stage A: per-channel absolute difference and square
   logic [CHAN_W-1:0] diff_red, diff_green, diff_blue;
   logic [SQ_W-1:0]   sq_red_ff, sq_green_ff, sq_blue_ff;
   logic [SQ_W-1:0]   sq_red_in, sq_green_in, sq_blue_in;
   scan_ctl_type      ctl_a_ff;
   logic [IDX_W-1:0]  idx_a_ff;

   // stage B: sum and running minimum
   logic [DIST_W-1:0] dist_sum;
   logic              take;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic              done_ff, done_in;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   always_comb begin
      diff_red    = abs_diff(query_red,   entry_in[CHAN_W-1:0]);
      diff_green  = abs_diff(query_green, entry_in[2*CHAN_W-1:CHAN_W]);
      diff_blue   = abs_diff(query_blue,  entry_in[3*CHAN_W-1:2*CHAN_W]);
      sq_red_in   = SQ_W'(diff_red)   * SQ_W'(diff_red);
      sq_green_in = SQ_W'(diff_green) * SQ_W'(diff_green);
      sq_blue_in  = SQ_W'(diff_blue)  * SQ_W'(diff_blue);
   end

   always_ff @(posedge clock) begin
      sq_red_ff   <= sq_red_in;
      sq_green_ff <= sq_green_in;
      sq_blue_ff  <= sq_blue_in;
      idx_a_ff    <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
      end else begin
         ctl_a_ff <= ctl_in;
      end
   end

   always_comb begin
      dist_sum = DIST_W'(sq_red_ff) + DIST_W'(sq_green_ff) + DIST_W'(sq_blue_ff);
      // strict less-than keeps the lowest index on ties
      take = ctl_a_ff.valid && (ctl_a_ff.first || (dist_sum < best_dist_ff));
      best_dist_in = take ? dist_sum : best_dist_ff;
      best_idx_in  = take ? idx_a_ff : best_idx_ff;
      done_in      = ctl_a_ff.valid && ctl_a_ff.last;
   end

   always_ff @(posedge clock) begin
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   assign best_index    = best_idx_ff;
   assign best_distance = best_dist_ff;
   assign done          = done_ff;

endmodule

// ===== src/palette_nearest_color_match.sv =====
// Top level of the nearest palette colour match block.
//
// Holds a palette of PALETTE_ENTRIES 24-bit RGB entries in a ring of cells,
// one entry per cell, all cleared to zero by reset. A load word writes one
// entry and is answered in the next cycle with its packed 32-bit word (alpha
// 255, or 0 for the last entry); an index beyond the palette leaves the ring
// untouched but is still answered. A query word carries a 15-bit colour whose
// 5-bit components are widened to 8 bits; the ring then rotates one step per
// cycle, handing every entry in turn past a single distance unit (square
// stage, then add-and-compare stage), and comes back to its home position
// when the scan ends. One query is in flight at a time. The result sits in
// an output register, so a new query is taken while an earlier result still
// waits; a load waits while a scan runs or while that register is full and
// not being drained. The lowest index wins ties.
module palette_nearest_color_match #(
   parameter int PALETTE_ENTRIES = pnc_pkg::PNC_ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [0:0]                   req_opcode,
   input  logic [pnc_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic [pnc_pkg::CHAN_W-1:0]   req_red,
   input  logic [pnc_pkg::CHAN_W-1:0]   req_green,
   input  logic [pnc_pkg::CHAN_W-1:0]   req_blue,
   input  logic [pnc_pkg::CODE_W-1:0]   req_color_code,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [0:0]                   rsp_result_kind,
   output logic [pnc_pkg::WORD_W-1:0]   rsp_packed_word,
   output logic [pnc_pkg::INDEX_W-1:0]  rsp_best_index,
   output logic [pnc_pkg::DIST_W-1:0]   rsp_best_distance
);
   import pnc_pkg::*;

`include "palette_nearest_color_match_defines.svh"

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);
   localparam logic [IDX_W-1:0]   LAST_SLOT  = IDX_W'(PALETTE_ENTRIES - 1);
   localparam logic [INDEX_W-1:0] LAST_ENTRY = INDEX_W'(PALETTE_ENTRIES - 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_FLUSH = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [CHAN_W-1:0] qry_red_ff, qry_green_ff, qry_blue_ff;

   logic              req_fire, load_fire, query_fire, out_free, emit_match;
   logic [ENTRY_W-1:0] load_rgb;
   logic [CHAN_W-1:0]  load_alpha;

   // palette ring
   logic [ENTRY_W-1:0] ring_q [PALETTE_ENTRIES];
   logic               ring_shift;

   // distance unit
   scan_ctl_type       scan_ctl;
   logic [IDX_W-1:0]   dist_best_index;
   logic [DIST_W-1:0]  dist_best_distance;
   logic               dist_done;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [0:0]         rsp_kind_ff, rsp_kind_in;
   logic [WORD_W-1:0]  rsp_word_ff, rsp_word_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;

   // ---------------------------------------------------------------- handshake
   // The output register is free when empty or being drained this cycle.
   assign out_free   = !rsp_valid_ff || rsp_ready;
   // A query only needs an idle ring; a load answers at once, so it also
   // needs room in the output register.
   assign req_ready  = (state_ff == ST_IDLE) && ((req_opcode == OP_QUERY) || out_free);
   assign req_fire   = req_valid && req_ready;
   assign load_fire  = req_fire && (req_opcode == OP_LOAD);
   assign query_fire = req_fire && (req_opcode == OP_QUERY);
   assign emit_match = (state_ff == ST_DONE) && out_free;

   assign load_rgb   = {req_blue, req_green, req_red};
   assign load_alpha = (req_entry_index == LAST_ENTRY) ? ALPHA_CLEAR : ALPHA_OPAQUE;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_fire) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            // advance one entry per cycle; the ring is home after the last step
            cnt_in = cnt_ff + IDX_W'(1);
            if (cnt_ff == LAST_SLOT) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (dist_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // hold the widened query colour for the whole scan
   always_ff @(posedge clock) begin
      if (query_fire) begin
         qry_red_ff   <= widen5(req_color_code[4:0]);
         qry_green_ff <= widen5(req_color_code[9:5]);
         qry_blue_ff  <= widen5(req_color_code[14:10]);
      end
   end

   // ---------------------------------------------------------------- palette ring
   // Each cell passes its entry to its lower neighbour while scanning; the
   // entry at cell 0 in scan step k is palette entry k.
   assign ring_shift = (state_ff == ST_SCAN);

   for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
      pnc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .load_en    (load_fire && (req_entry_index == INDEX_W'(i))),
         .load_data  (load_rgb),
         .shift_en   (ring_shift),
         .shift_data (ring_q[(i + 1) % PALETTE_ENTRIES]),
         .entry_q    (ring_q[i])
      );
   end

   // ---------------------------------------------------------------- distance unit
   always_comb begin
      scan_ctl.valid = (state_ff == ST_SCAN);
      scan_ctl.first = (cnt_ff == '0);
      scan_ctl.last  = (cnt_ff == LAST_SLOT);
   end

   pnc_dist #(
      .IDX_W (IDX_W)
   ) u_dist (
      .clock         (clock),
      .reset         (reset),
      .ctl_in        (scan_ctl),
      .idx_in        (cnt_ff),
      .entry_in      (ring_q[0]),
      .query_red     (qry_red_ff),
      .query_green   (qry_green_ff),
      .query_blue    (qry_blue_ff),
      .best_index    (dist_best_index),
      .best_distance (dist_best_distance),
      .done          (dist_done)
   );

   // ---------------------------------------------------------------- output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_index_in = rsp_index_ff;
      rsp_dist_in  = rsp_dist_ff;
      priority if (load_fire) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_ACK;
         rsp_word_in  = {load_alpha, load_rgb};
         rsp_index_in = '0;
         rsp_dist_in  = '0;
      end else if (emit_match) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_MATCH;
         rsp_word_in  = '0;
         rsp_index_in = INDEX_W'(dist_best_index);
         rsp_dist_in  = dist_best_distance;
      end else if (rsp_ready) begin
         // drop the word once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_packed_word   = rsp_word_ff;
   assign rsp_best_index    = rsp_index_ff;
   assign rsp_best_distance = rsp_dist_ff;

   // ---------------------------------------------------------------- assertions
   `PNC_ASSERT_NEXT(a_query_starts_scan, clock, reset, query_fire, (state_ff == ST_SCAN) && (cnt_ff == '0), "query did not start a scan at slot zero")
   `PNC_ASSERT_NOW(a_done_only_in_flush, clock, reset, dist_done, state_ff == ST_FLUSH, "distance unit finished outside the flush state")
   `PNC_ASSERT_NOW(a_ack_fields_clear, clock, reset, rsp_valid && (rsp_result_kind == KIND_ACK), (rsp_best_index == '0) && (rsp_best_distance == '0), "load acknowledge carries match fields")

endmodule
